FILE: rtl/bsmm_pkg.sv
// bsmm_pkg: shared types and constants for the bitmap set with count and min/max tracking
// no dependencies; imported by bitmap_set_with_min_max_count_top
package bsmm_pkg;

	// field widths fixed by the interface
	localparam int VALUE_W  = 11;
	localparam int ACTION_W = 2;

	// default store geometry
	localparam int DEF_CAPACITY  = 1024;
	localparam int DEF_WORD_BITS = 32;

	// set limit after reset
	localparam logic [VALUE_W-1:0] SET_LIMIT_RST = 11'd1024;

	// requested action per beat
	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_TEST   = 2'd2,
		ACT_INVERT = 2'd3
	} action_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_CFG_DIV,
		S_CFG_OFF,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_INV_RD,
		S_INV_WR,
		S_SF_RD,
		S_SF_EV,
		S_SL_RD,
		S_SL_EV,
		S_DONE
	} state_t;

endpackage

FILE: rtl/bsmm_bit_scan.sv
// bsmm_bit_scan: shared scan unit, finds lowest and highest set bit of one store word
// parameterized by word width; no package dependency
module bsmm_bit_scan #(
	parameter int WORD_BITS = 32,
	parameter int IDX_W     = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [IDX_W-1:0]     low_idx,
	output logic [IDX_W-1:0]     high_idx
);

	// any bit set
	assign found = |word;

	// priority encoders from both ends
	always_comb begin
		low_idx  = '0;
		high_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) low_idx = IDX_W'(i);
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (word[i]) high_idx = IDX_W'(i);
		end
	end

endmodule

FILE: rtl/bitmap_set_with_min_max_count_top.sv
// Set of values 1..limit kept as a word store with member count, smallest and largest
// member. One beat in gives one beat out. Add and test read and evaluate one word; a
// delete of the smallest or largest member adds a read and an evaluate step per store
// word walked by the rescan; invert first reads and rewrites each word up to eff_max.
// All store accesses share one read and one write port and one bit-scan unit. After
// reset and after every limit write a clearing pass over all CAPACITY / WORD_BITS
// (rounded up) words runs while cmd_stall is high. A finished result waits in the
// output register, so a new command is taken while the prior result is still stalled.
// depends on bsmm_pkg and bsmm_bit_scan
module bitmap_set_with_min_max_count_top
	import bsmm_pkg::*;
#(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_write_en,
	input  logic [VALUE_W-1:0]  cfg_write_data,
	// command channel
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [VALUE_W-1:0]  value,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                ok,
	output logic                is_member,
	output logic [VALUE_W-1:0]  member_count,
	output logic [VALUE_W-1:0]  first_member,
	output logic [VALUE_W-1:0]  last_member
);

	localparam int NWORDS      = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int AW          = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int OFF_W       = $clog2(WORD_BITS);
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NWORDS - 1);

	// word store
	logic [WORD_BITS-1:0] mem [NWORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;

	// control state
	state_t               state_q, state_d;
	logic [AW-1:0]        scan_idx_q;
	logic [VALUE_W-1:0]   max_q;
	logic [VALUE_W-1:0]   count_q;
	logic [VALUE_W-1:0]   first_q;
	logic [VALUE_W-1:0]   last_q;
	logic                 out_valid_q;

	// per-item and geometry registers
	action_t              act_q;
	logic [VALUE_W-1:0]   val_q;
	logic                 inr_q;
	logic [VALUE_W-1:0]   q_q;
	logic [OFF_W-1:0]     off_q;
	logic                 ok_q;
	logic                 member_q;
	logic                 need_last_q;
	logic [AW-1:0]        last_word_q;
	logic [WORD_BITS-1:0] last_mask_q;

	// output register
	logic                 ok_out_q;
	logic                 member_out_q;
	logic [VALUE_W-1:0]   count_out_q;
	logic [VALUE_W-1:0]   first_out_q;
	logic [VALUE_W-1:0]   last_out_q;

	// datapath nets
	logic [VALUE_W-1:0]   eff_max;
	logic                 cmd_inr;
	logic [VALUE_W-1:0]   pos_d;
	logic [PROD_W-1:0]    prod;
	logic [VALUE_W-1:0]   q_d;
	logic [OFF_W-1:0]     off_d;
	logic [WORD_BITS-1:0] mask_d;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 cur_bit;
	logic [WORD_BITS-1:0] inv_word;
	logic [WORD_BITS-1:0] scan_word;
	logic                 scan_found;
	logic [OFF_W-1:0]     scan_lo;
	logic [OFF_W-1:0]     scan_hi;
	logic [VALUE_W-1:0]   scan_lo_val;
	logic [VALUE_W-1:0]   scan_hi_val;
	logic                 out_load;

	// effective maximum and range check of an incoming beat
	assign eff_max = (32'(max_q) > CAPACITY) ? VALUE_W'(CAPACITY) : max_q;
	assign cmd_inr = (value != '0) && (value <= eff_max);

	// shared divider by WORD_BITS: reciprocal multiply, remainder from the registered quotient
	always_comb begin
		unique case (state_q)
			S_IDLE:               pos_d = value - VALUE_W'(1);
			S_CFG_DIV, S_CFG_OFF: pos_d = eff_max - VALUE_W'(1);
			default:              pos_d = val_q - VALUE_W'(1);
		endcase
	end
	assign prod   = PROD_W'(pos_d) * PROD_W'(RECIP);
	assign q_d    = VALUE_W'(prod >> RECIP_SHIFT);
	assign off_d  = OFF_W'(pos_d - VALUE_W'(32'(q_q) * WORD_BITS));
	assign mask_d = ~(({WORD_BITS{1'b1}} << off_d) << 1);

	// bit of the addressed value and inverted word
	assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << off_q;
	assign cur_bit  = rdata_q[off_q];
	assign inv_word = ~rdata_q & ((scan_idx_q == last_word_q) ? last_mask_q
		: {WORD_BITS{1'b1}});

	// shared scan unit, fed the inverted word while inverting
	assign scan_word = (state_q == S_INV_WR) ? inv_word : rdata_q;
	bsmm_bit_scan #(
		.WORD_BITS (WORD_BITS),
		.IDX_W     (OFF_W)
	) u_scan (
		.word     (scan_word),
		.found    (scan_found),
		.low_idx  (scan_lo),
		.high_idx (scan_hi)
	);
	assign scan_lo_val = VALUE_W'(32'(scan_idx_q) * WORD_BITS + 32'(scan_lo) + 1);
	assign scan_hi_val = VALUE_W'(32'(scan_idx_q) * WORD_BITS + 32'(scan_hi) + 1);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !rsp_stall);

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	// next state and store controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = scan_idx_q;
		mem_wdata = '0;
		mem_raddr = scan_idx_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (scan_idx_q == LAST_ADDR) state_d = S_CFG_DIV;
			end
			S_CFG_DIV: state_d = S_CFG_OFF;
			S_CFG_OFF: state_d = S_IDLE;
			S_IDLE: begin
				if (cmd_valid) begin
					if (action_t'(action) == ACT_INVERT && eff_max != '0) state_d = S_INV_RD;
					else state_d = S_READ;
				end
			end
			S_READ: begin
				mem_raddr = AW'(q_q);
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				state_d   = S_DONE;
				mem_waddr = AW'(q_q);
				if (act_q == ACT_ADD && inr_q && !cur_bit) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q | bit_mask;
				end else if (act_q == ACT_DELETE && inr_q && cur_bit) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q & ~bit_mask;
					if (val_q == first_q)     state_d = S_SF_RD;
					else if (val_q == last_q) state_d = S_SL_RD;
				end
			end
			S_INV_RD: state_d = S_INV_WR;
			S_INV_WR: begin
				mem_we    = 1'b1;
				mem_wdata = inv_word;
				if (scan_idx_q == last_word_q) state_d = S_READ;
				else state_d = S_INV_RD;
			end
			S_SF_RD: state_d = S_SF_EV;
			S_SF_EV: begin
				if (scan_found || scan_idx_q == last_word_q)
					state_d = need_last_q ? S_SL_RD : S_DONE;
				else
					state_d = S_SF_RD;
			end
			S_SL_RD: state_d = S_SL_EV;
			S_SL_EV: begin
				if (scan_found || scan_idx_q == '0) state_d = S_DONE;
				else state_d = S_SL_RD;
			end
			S_DONE: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
		if (cfg_write_en) state_d = S_CLEAR;
	end

	// set summary, sweep pointer, config register and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			max_q       <= SET_LIMIT_RST;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: scan_idx_q <= scan_idx_q + AW'(1);
				S_IDLE: begin
					if (cmd_valid && action_t'(action) == ACT_INVERT && eff_max != '0) begin
						count_q    <= eff_max - count_q;
						first_q    <= '0;
						last_q     <= '0;
						scan_idx_q <= '0;
					end
				end
				S_EVAL: begin
					if (act_q == ACT_ADD && inr_q && !cur_bit) begin
						count_q <= count_q + VALUE_W'(1);
						if (first_q == '0 || val_q < first_q) first_q <= val_q;
						if (val_q > last_q) last_q <= val_q;
					end else if (act_q == ACT_DELETE && inr_q && cur_bit) begin
						count_q    <= count_q - VALUE_W'(1);
						scan_idx_q <= AW'(q_q);
					end
				end
				S_INV_WR: begin
					if (scan_found) begin
						if (first_q == '0) first_q <= scan_lo_val;
						last_q <= scan_hi_val;
					end
					if (scan_idx_q != last_word_q) scan_idx_q <= scan_idx_q + AW'(1);
				end
				S_SF_EV: begin
					if (scan_found) first_q <= scan_lo_val;
					else if (scan_idx_q == last_word_q) first_q <= '0;
					if (scan_found || scan_idx_q == last_word_q) scan_idx_q <= AW'(q_q);
					else scan_idx_q <= scan_idx_q + AW'(1);
				end
				S_SL_EV: begin
					if (scan_found) last_q <= scan_hi_val;
					else if (scan_idx_q == '0) last_q <= '0;
					else scan_idx_q <= scan_idx_q - AW'(1);
				end
				default: ;
			endcase
			// new maximum starts an empty set
			if (cfg_write_en) begin
				max_q      <= cfg_write_data;
				count_q    <= '0;
				first_q    <= '0;
				last_q     <= '0;
				scan_idx_q <= '0;
			end
		end
	end

	// per-item registers and response payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				act_q <= action_t'(action);
				val_q <= value;
				inr_q <= cmd_inr;
				q_q   <= q_d;
			end
			S_CFG_DIV: q_q <= q_d;
			S_CFG_OFF: begin
				last_word_q <= AW'(q_q);
				last_mask_q <= mask_d;
			end
			S_READ: off_q <= off_d;
			S_EVAL: begin
				need_last_q <= (val_q == last_q);
				unique case (act_q)
					ACT_ADD: begin
						ok_q     <= inr_q;
						member_q <= inr_q;
					end
					ACT_DELETE: begin
						ok_q     <= inr_q && cur_bit;
						member_q <= 1'b0;
					end
					ACT_TEST: begin
						ok_q     <= inr_q;
						member_q <= inr_q && cur_bit;
					end
					ACT_INVERT: begin
						ok_q     <= 1'b1;
						member_q <= inr_q && cur_bit;
					end
				endcase
			end
			default: ;
		endcase
		if (out_load) begin
			ok_out_q     <= ok_q;
			member_out_q <= member_q;
			count_out_q  <= count_q;
			first_out_q  <= first_q;
			last_out_q   <= last_q;
		end
	end

	// ports
	assign cmd_stall    = (state_q != S_IDLE);
	assign rsp_valid    = out_valid_q;
	assign ok           = ok_out_q;
	assign is_member    = member_out_q;
	assign member_count = count_out_q;
	assign first_member = first_out_q;
	assign last_member  = last_out_q;

	// count never exceeds the active range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> count_q <= eff_max)
		else $error("member count above effective maximum");

	// empty set exactly when first and last are zero
	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((count_q == '0) == (first_q == '0))
			&& ((count_q == '0) == (last_q == '0)))
		else $error("first/last out of step with member count");

	// smallest member never above largest
	a_first_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> first_q <= last_q)
		else $error("first member above last member");

	// a limit write restarts with an empty set and a clearing pass
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> state_q == S_CLEAR && count_q == '0 && scan_idx_q == '0)
		else $error("configuration write did not restart the clearing pass");

endmodule
